### sv/uhs_pkg.sv
// Shared types, codes and constants of the unit health supervisor.
package uhs_pkg;

  localparam int UNITS_DEF   = 16;
  localparam int UNIT_W      = 4;
  localparam int OP_W        = 4;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap by themselves
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  RESTART_LIMIT_RST  = 8'd3;
  localparam logic [15:0] RESTART_WINDOW_RST = 16'd60;
  localparam logic [7:0]  MISS_FAIL_LIMIT    = 8'd3;
  localparam logic [7:0]  MISS_DEGRADE_LIMIT = 8'd2;

  // Register index as decoded from paddr[2].
  localparam logic REG_RESTART_LIMIT  = 1'b0;
  localparam logic REG_RESTART_WINDOW = 1'b1;

  // Operation codes on the input channel.
  localparam logic [OP_W-1:0] OPC_REGISTER  = 4'd0;
  localparam logic [OP_W-1:0] OPC_ADD_DEP   = 4'd1;
  localparam logic [OP_W-1:0] OPC_HEARTBEAT = 4'd2;
  localparam logic [OP_W-1:0] OPC_MISSED    = 4'd3;
  localparam logic [OP_W-1:0] OPC_CRASH     = 4'd4;
  localparam logic [OP_W-1:0] OPC_RESTART   = 4'd5;
  localparam logic [OP_W-1:0] OPC_STOP      = 4'd6;
  localparam logic [OP_W-1:0] OPC_ENFORCE   = 4'd7;
  localparam logic [OP_W-1:0] OPC_TICK      = 4'd8;
  localparam logic [OP_W-1:0] OPC_QUERY     = 4'd9;

  typedef enum logic [3:0] {
    CLS_REGISTER,
    CLS_ADD_DEP,
    CLS_HEARTBEAT,
    CLS_MISSED,
    CLS_CRASH,
    CLS_RESTART,
    CLS_STOP,
    CLS_ENFORCE,
    CLS_TICK,
    CLS_QUERY,
    CLS_BAD
  } cls_t;

  typedef enum logic [1:0] {
    MODE_RUNNING    = 2'd0,
    MODE_DEGRADED   = 2'd1,
    MODE_RECOVERING = 2'd2,
    MODE_FAILED     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOREG  = 2'd1,
    ST_REJECT = 2'd2
  } st_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] other_unit;
    logic              spawn_ok;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  status;
    logic [1:0]  unit_mode_out;
    logic [15:0] restart_count_out;
    logic [7:0]  window_restarts_out;
    logic [7:0]  missed_count_out;
  } out_item_t;

  // Classified event as it waits between front and back end.
  typedef struct packed {
    cls_t              cls;
    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] other_unit;
    logic              spawn_ok;
    logic              unit_ok;
    logic              other_ok;
  } work_t;

endpackage

### sv/unit_health_supervisor_top.sv
// Top level of the unit health supervisor: front end, back end and register port.
//
// Keeps a health record for each of UNITS slots (mode, missed heartbeats,
// total and windowed restart counts, dependents mask) and returns one result
// transfer per event transfer, in order. The front end takes an event in the
// cycle it is offered while its two-entry queue has room; the back end then
// takes each event through S_FETCH, which reads the slot and compares the time
// since the window start against restart_window_s, and S_APPLY, which updates
// the record, degrades dependents and loads the result register, waiting there
// while a held result is stalled. The back end fetches no new event before the
// last one has committed its result. Still, a held result does not block
// the front end, which keeps filling its queue. Slot valid bits clear at reset,
// so the block takes events right after reset with no clearing pass. Write
// the restart limit (byte address 0) and restart_window_s (byte address 4)
// only while no event is in flight; reads return the stored values, pready is
// tied high.
module unit_health_supervisor_top #(
  parameter int UNITS = uhs_pkg::UNITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  uhs_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output uhs_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uhs_pkg::PADDR_W-1:0] paddr,
  input  logic [uhs_pkg::PDATA_W-1:0] pwdata,
  output logic [uhs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  logic [7:0]     restart_limit_r;
  logic [15:0]    restart_window_r;
  logic           cfg_wr;
  logic           q_valid;
  logic           q_pop;
  uhs_pkg::work_t q_item;

  // Register port: write in the access phase, word select on paddr[2].
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_limit_r  <= uhs_pkg::RESTART_LIMIT_RST;
      restart_window_r <= uhs_pkg::RESTART_WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        uhs_pkg::REG_RESTART_LIMIT:  restart_limit_r  <= pwdata[7:0];
        uhs_pkg::REG_RESTART_WINDOW: restart_window_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      uhs_pkg::REG_RESTART_LIMIT:  prdata = uhs_pkg::PDATA_W'(restart_limit_r);
      uhs_pkg::REG_RESTART_WINDOW: prdata = uhs_pkg::PDATA_W'(restart_window_r);
      default:                     prdata = '0;
    endcase
  end

  // Classify and queue incoming events.
  uhs_front #(
    .UNITS (UNITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // Execute events against the records and hold the result for transfer.
  uhs_back #(
    .UNITS (UNITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_item           (q_item),
    .restart_limit    (restart_limit_r),
    .restart_window_s (restart_window_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item         (out_item)
  );

endmodule

### sv/uhs_front.sv
// Front end: accepts events, classifies them and queues them for the back end.
module uhs_front #(
  parameter int UNITS = uhs_pkg::UNITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  uhs_pkg::in_item_t in_item,
  output logic              q_valid,
  input  logic              q_pop,
  output uhs_pkg::work_t    q_item
);

  uhs_pkg::work_t                   entries_r [uhs_pkg::QUEUE_DEPTH];
  logic [uhs_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [uhs_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [uhs_pkg::QCNT_W-1:0]       cnt_r;
  logic [uhs_pkg::QCNT_W-1:0]       cnt_nxt;
  logic                             push;
  uhs_pkg::work_t                   cls_item;

  assign in_stall = (cnt_r == uhs_pkg::QCNT_W'(uhs_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = entries_r[rd_ptr_r];

  // Classify: map the op code and flag slot numbers outside the table.
  always_comb begin
    cls_item.unit       = in_item.unit;
    cls_item.other_unit = in_item.other_unit;
    cls_item.spawn_ok   = in_item.spawn_ok;
    cls_item.unit_ok    = (32'(in_item.unit) < 32'(UNITS));
    cls_item.other_ok   = (32'(in_item.other_unit) < 32'(UNITS));
    unique case (in_item.operation)
      uhs_pkg::OPC_REGISTER:  cls_item.cls = uhs_pkg::CLS_REGISTER;
      uhs_pkg::OPC_ADD_DEP:   cls_item.cls = uhs_pkg::CLS_ADD_DEP;
      uhs_pkg::OPC_HEARTBEAT: cls_item.cls = uhs_pkg::CLS_HEARTBEAT;
      uhs_pkg::OPC_MISSED:    cls_item.cls = uhs_pkg::CLS_MISSED;
      uhs_pkg::OPC_CRASH:     cls_item.cls = uhs_pkg::CLS_CRASH;
      uhs_pkg::OPC_RESTART:   cls_item.cls = uhs_pkg::CLS_RESTART;
      uhs_pkg::OPC_STOP:      cls_item.cls = uhs_pkg::CLS_STOP;
      uhs_pkg::OPC_ENFORCE:   cls_item.cls = uhs_pkg::CLS_ENFORCE;
      uhs_pkg::OPC_TICK:      cls_item.cls = uhs_pkg::CLS_TICK;
      uhs_pkg::OPC_QUERY:     cls_item.cls = uhs_pkg::CLS_QUERY;
      default:                cls_item.cls = uhs_pkg::CLS_BAD;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + uhs_pkg::QCNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - uhs_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + uhs_pkg::QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + uhs_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

### sv/uhs_back.sv
// Back end: health records, event execution and the result register.
module uhs_back #(
  parameter int UNITS = uhs_pkg::UNITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  uhs_pkg::work_t     q_item,
  input  logic [7:0]         restart_limit,
  input  logic [15:0]        restart_window_s,
  output logic               out_valid,
  input  logic               out_stall,
  output uhs_pkg::out_item_t out_item
);

  localparam int IDX_W = (UNITS > 1) ? $clog2(UNITS) : 1;

  typedef enum logic {
    S_FETCH,
    S_APPLY
  } state_t;

  state_t             state_r;
  uhs_pkg::work_t     work_r;
  logic               over_r;
  logic               out_valid_r;
  uhs_pkg::out_item_t out_item_r;

  // Record storage, one entry per slot.
  logic [UNITS-1:0]   valid_r;
  logic [UNITS-1:0]   valid_nxt;
  uhs_pkg::mode_t     mode_r   [UNITS];
  uhs_pkg::mode_t     mode_nxt [UNITS];
  logic [15:0]        rtot_r   [UNITS];
  logic [7:0]         wrst_r   [UNITS];
  logic [7:0]         miss_r   [UNITS];
  logic [31:0]        wstart_r [UNITS];
  logic [UNITS-1:0]   deps_r   [UNITS];
  logic [UNITS-1:0]   deps_nxt [UNITS];
  logic [31:0]        now_r;

  logic [IDX_W-1:0]   f_idx;
  logic [IDX_W-1:0]   a_idx;
  logic [IDX_W-1:0]   o_idx;
  logic               over_nxt;
  logic               out_free;
  logic               commit;

  logic               live;
  logic               o_live;
  uhs_pkg::mode_t     cur_mode;
  logic               failed;
  uhs_pkg::mode_t     own_mode;
  logic [15:0]        own_rtot;
  logic [7:0]         own_wrst;
  logic [7:0]         own_miss;
  logic [7:0]         bud_base;
  logic [7:0]         bud_wrst;
  uhs_pkg::mode_t     bud_mode;
  logic [7:0]         miss_inc;
  logic [15:0]        rtot_inc;
  logic               wr_own;
  logic               wr_start;
  logic               set_valid;
  logic               clear_col;
  logic               add_dep;
  logic               do_degrade;
  logic               do_restart;
  logic               tick;
  logic               acc;
  uhs_pkg::st_t       status;
  logic               live_after;
  uhs_pkg::out_item_t out_nxt;

  assign f_idx    = IDX_W'(q_item.unit);
  assign a_idx    = IDX_W'(work_r.unit);
  assign o_idx    = IDX_W'(work_r.other_unit);
  assign q_pop    = (state_r == S_FETCH) && q_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == S_APPLY) && out_free;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Elapsed-time check of the restart window, taken while fetching.
  assign over_nxt = (now_r - wstart_r[f_idx]) > 32'(restart_window_s);

  // Budget arithmetic shared by crash, missed and enforce.
  always_comb begin
    cur_mode = mode_r[a_idx];
    failed   = (cur_mode == uhs_pkg::MODE_FAILED);
    live     = work_r.unit_ok && valid_r[a_idx];
    o_live   = work_r.other_ok && valid_r[o_idx];
    bud_base = over_r ? 8'd0 : wrst_r[a_idx];
    bud_wrst = (&bud_base) ? bud_base : bud_base + 8'd1;
    bud_mode = (bud_wrst > restart_limit) ? uhs_pkg::MODE_FAILED : uhs_pkg::MODE_RECOVERING;
    miss_inc = (&miss_r[a_idx]) ? miss_r[a_idx] : miss_r[a_idx] + 8'd1;
    rtot_inc = (&rtot_r[a_idx]) ? rtot_r[a_idx] : rtot_r[a_idx] + 16'd1;
  end

  // Event execution.
  always_comb begin
    own_mode   = cur_mode;
    own_rtot   = rtot_r[a_idx];
    own_wrst   = wrst_r[a_idx];
    own_miss   = miss_r[a_idx];
    wr_own     = 1'b0;
    wr_start   = 1'b0;
    set_valid  = 1'b0;
    clear_col  = 1'b0;
    add_dep    = 1'b0;
    do_degrade = 1'b0;
    do_restart = 1'b0;
    tick       = 1'b0;
    acc        = 1'b0;
    status     = uhs_pkg::ST_OK;

    priority if (work_r.cls == uhs_pkg::CLS_REGISTER) begin
      if (live && !failed) begin
        status = uhs_pkg::ST_REJECT;
      end else if (!work_r.unit_ok) begin
        status = uhs_pkg::ST_NOREG;
      end else if (work_r.spawn_ok) begin
        own_mode  = uhs_pkg::MODE_RUNNING;
        own_rtot  = '0;
        own_wrst  = '0;
        own_miss  = '0;
        wr_own    = 1'b1;
        wr_start  = 1'b1;
        set_valid = 1'b1;
        clear_col = 1'b1;
        acc       = 1'b1;
      end
    end else if (work_r.cls == uhs_pkg::CLS_TICK) begin
      tick = 1'b1;
    end else if (work_r.cls == uhs_pkg::CLS_BAD) begin
      status = uhs_pkg::ST_REJECT;
    end else if (!live) begin
      status = uhs_pkg::ST_NOREG;
    end else begin
      unique case (work_r.cls)
        uhs_pkg::CLS_ADD_DEP: begin
          if (!o_live) begin
            status = uhs_pkg::ST_NOREG;
          end else begin
            add_dep = 1'b1;
            acc     = 1'b1;
          end
        end
        uhs_pkg::CLS_HEARTBEAT: begin
          if (!failed) begin
            own_miss = '0;
            wr_own   = 1'b1;
            if (cur_mode == uhs_pkg::MODE_DEGRADED) begin
              own_mode = uhs_pkg::MODE_RUNNING;
            end
          end
        end
        uhs_pkg::CLS_MISSED: begin
          if (!failed) begin
            own_miss = miss_inc;
            wr_own   = 1'b1;
            if (miss_inc >= uhs_pkg::MISS_FAIL_LIMIT) begin
              do_restart = 1'b1;
            end else if (miss_inc >= uhs_pkg::MISS_DEGRADE_LIMIT) begin
              own_mode = uhs_pkg::MODE_DEGRADED;
            end
          end
        end
        uhs_pkg::CLS_CRASH: begin
          if (!failed) begin
            do_restart = 1'b1;
          end
        end
        uhs_pkg::CLS_RESTART: begin
          if (cur_mode != uhs_pkg::MODE_RECOVERING) begin
            status = uhs_pkg::ST_REJECT;
          end else if (work_r.spawn_ok) begin
            own_miss = '0;
            own_mode = uhs_pkg::MODE_RUNNING;
            wr_own   = 1'b1;
            acc      = 1'b1;
          end else begin
            own_mode   = uhs_pkg::MODE_FAILED;
            wr_own     = 1'b1;
            do_degrade = 1'b1;
          end
        end
        uhs_pkg::CLS_STOP: begin
          if (!failed) begin
            own_mode   = uhs_pkg::MODE_FAILED;
            wr_own     = 1'b1;
            do_degrade = 1'b1;
          end
        end
        uhs_pkg::CLS_ENFORCE: begin
          own_wrst = bud_wrst;
          own_mode = bud_mode;
          wr_start = over_r;
          wr_own   = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Count a restart, run the budget check, then hit the dependents.
    if (do_restart) begin
      own_rtot   = rtot_inc;
      own_wrst   = bud_wrst;
      own_mode   = bud_mode;
      wr_start   = over_r;
      wr_own     = 1'b1;
      do_degrade = 1'b1;
    end
  end

  // Next values of the per-slot arrays: own update first, dependents after.
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < UNITS; i++) begin
      mode_nxt[i] = mode_r[i];
      deps_nxt[i] = deps_r[i];
    end
    if (set_valid) begin
      valid_nxt[a_idx] = 1'b1;
    end
    if (wr_own) begin
      mode_nxt[a_idx] = own_mode;
    end
    if (do_degrade) begin
      for (int d = 0; d < UNITS; d++) begin
        if (deps_r[a_idx][d] && valid_r[d] && mode_nxt[d] != uhs_pkg::MODE_FAILED) begin
          mode_nxt[d] = uhs_pkg::MODE_DEGRADED;
        end
      end
    end
    if (clear_col) begin
      for (int i = 0; i < UNITS; i++) begin
        deps_nxt[i][a_idx] = 1'b0;
      end
      deps_nxt[a_idx] = '0;
    end
    if (add_dep) begin
      deps_nxt[o_idx][a_idx] = 1'b1;
    end
  end

  always_comb begin
    live_after                  = work_r.unit_ok && valid_nxt[a_idx];
    out_nxt.accepted            = acc;
    out_nxt.status              = status;
    out_nxt.unit_mode_out       = live_after ? mode_nxt[a_idx] : 2'd0;
    out_nxt.restart_count_out   = live_after ? own_rtot : 16'd0;
    out_nxt.window_restarts_out = live_after ? own_wrst : 8'd0;
    out_nxt.missed_count_out    = live_after ? own_miss : 8'd0;
  end

  // Sequencer, work register and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once the held one transfers.
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_FETCH: begin
          if (q_valid) begin
            work_r  <= q_item;
            over_r  <= over_nxt;
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (out_free) begin
            out_item_r <= out_nxt;
            state_r    <= S_FETCH;
          end
        end
        default: begin
          state_r <= S_FETCH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      now_r   <= '0;
    end else if (commit) begin
      valid_r <= valid_nxt;
      if (tick) begin
        now_r <= now_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      for (int i = 0; i < UNITS; i++) begin
        mode_r[i] <= mode_nxt[i];
        deps_r[i] <= deps_nxt[i];
      end
      if (wr_own) begin
        rtot_r[a_idx] <= own_rtot;
        wrst_r[a_idx] <= own_wrst;
        miss_r[a_idx] <= own_miss;
      end
      if (wr_start) begin
        wstart_r[a_idx] <= now_r;
      end
    end
  end

endmodule

### sv/uhs_checker.sv
// Port-level checks of the unit health supervisor and their bind.
module uhs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input uhs_pkg::out_item_t out_item
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The status field only carries the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status <= uhs_pkg::ST_REJECT)
    else $error("status outside the defined codes");

  // Success always comes with ok status.
  a_accept_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.accepted |-> out_item.status == uhs_pkg::ST_OK)
    else $error("accepted with non-ok status");

endmodule

bind unit_health_supervisor_top uhs_checker u_uhs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

### bench/unit_health_supervisor_checker.sv
// Checker for the unit health supervisor: tracks health records and compares every result.
module unit_health_supervisor_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  uhs_pkg::in_item_t           in_item,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  uhs_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uhs_pkg::PADDR_W-1:0] paddr,
  input  logic [uhs_pkg::PDATA_W-1:0] pwdata,
  input  logic [uhs_pkg::PDATA_W-1:0] prdata,
  input  logic                        pready,
  output int                          mismatches,
  output int                          outstanding
);
  import uhs_pkg::*;

  logic [7:0]           restart_limit;
  logic [15:0]          window_len;
  logic                 slot_used      [UNITS_DEF];
  mode_t                slot_mode      [UNITS_DEF];
  logic [15:0]          total_restarts [UNITS_DEF];
  logic [7:0]           win_restarts   [UNITS_DEF];
  logic [7:0]           missed         [UNITS_DEF];
  logic [31:0]          win_start      [UNITS_DEF];
  logic [UNITS_DEF-1:0] dep_mask       [UNITS_DEF];
  logic [31:0]          seconds;

  out_item_t expected_reports[$];
  int        fails;

  function automatic void degrade_dependents_of(logic [UNIT_W-1:0] u);
    for (int d = 0; d < UNITS_DEF; d++)
      if (dep_mask[u][d] && slot_used[d] && slot_mode[d] != MODE_FAILED)
        slot_mode[d] = MODE_DEGRADED;
  endfunction

  // Restart the window once it has run out, then count and judge the budget.
  function automatic void charge_budget(logic [UNIT_W-1:0] u);
    logic [31:0] elapsed;
    elapsed = seconds - win_start[u];
    if (elapsed > {16'd0, window_len}) begin
      win_start[u]    = seconds;
      win_restarts[u] = 8'd0;
    end
    if (win_restarts[u] != 8'hFF)
      win_restarts[u]++;
    slot_mode[u] = (win_restarts[u] > restart_limit) ? MODE_FAILED : MODE_RECOVERING;
  endfunction

  function automatic void count_restart(logic [UNIT_W-1:0] u);
    if (total_restarts[u] != 16'hFFFF)
      total_restarts[u]++;
    charge_budget(u);
    degrade_dependents_of(u);
  endfunction

  // Apply one event to the records and return the result it must produce.
  function automatic out_item_t health_after(in_item_t ev);
    out_item_t         r;
    logic [UNIT_W-1:0] u;
    logic [UNIT_W-1:0] o;
    u = ev.unit;
    o = ev.other_unit;
    r = '0;
    if (ev.operation == OPC_REGISTER) begin
      if (slot_used[u] && slot_mode[u] != MODE_FAILED) begin
        r.status = ST_REJECT;
      end else if (ev.spawn_ok) begin
        slot_used[u]      = 1'b1;
        slot_mode[u]      = MODE_RUNNING;
        total_restarts[u] = '0;
        win_restarts[u]   = '0;
        missed[u]         = '0;
        win_start[u]      = seconds;
        dep_mask[u]       = '0;
        for (int i = 0; i < UNITS_DEF; i++)
          dep_mask[i][u] = 1'b0;
        r.accepted = 1'b1;
      end
    end else if (ev.operation == OPC_TICK) begin
      seconds++;
    end else if (ev.operation > OPC_QUERY) begin
      r.status = ST_REJECT;
    end else if (!slot_used[u]) begin
      r.status = ST_NOREG;
    end else begin
      case (ev.operation)
        OPC_ADD_DEP: begin
          if (!slot_used[o]) begin
            r.status = ST_NOREG;
          end else begin
            dep_mask[o][u] = 1'b1;
            r.accepted     = 1'b1;
          end
        end
        OPC_HEARTBEAT: begin
          if (slot_mode[u] != MODE_FAILED) begin
            missed[u] = '0;
            if (slot_mode[u] == MODE_DEGRADED)
              slot_mode[u] = MODE_RUNNING;
          end
        end
        OPC_MISSED: begin
          if (slot_mode[u] != MODE_FAILED) begin
            if (missed[u] != 8'hFF)
              missed[u]++;
            if (missed[u] >= MISS_FAIL_LIMIT)
              count_restart(u);
            else if (missed[u] >= MISS_DEGRADE_LIMIT)
              slot_mode[u] = MODE_DEGRADED;
          end
        end
        OPC_CRASH: begin
          if (slot_mode[u] != MODE_FAILED)
            count_restart(u);
        end
        OPC_RESTART: begin
          if (slot_mode[u] != MODE_RECOVERING) begin
            r.status = ST_REJECT;
          end else if (ev.spawn_ok) begin
            missed[u]    = '0;
            slot_mode[u] = MODE_RUNNING;
            r.accepted   = 1'b1;
          end else begin
            slot_mode[u] = MODE_FAILED;
            degrade_dependents_of(u);
          end
        end
        OPC_STOP: begin
          if (slot_mode[u] != MODE_FAILED) begin
            slot_mode[u] = MODE_FAILED;
            degrade_dependents_of(u);
          end
        end
        OPC_ENFORCE: charge_budget(u);
        default: ;
      endcase
    end
    if (slot_used[u]) begin
      r.unit_mode_out       = slot_mode[u];
      r.restart_count_out   = total_restarts[u];
      r.window_restarts_out = win_restarts[u];
      r.missed_count_out    = missed[u];
    end
    return r;
  endfunction

  task automatic flag(input string what);
    fails++;
    if (fails <= 10)
      $display("%0t checker: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : watch
    out_item_t   want;
    logic [31:0] reg_value;
    if (!rst_n) begin
      restart_limit = RESTART_LIMIT_RST;
      window_len    = RESTART_WINDOW_RST;
      seconds       = '0;
      for (int i = 0; i < UNITS_DEF; i++) begin
        slot_used[i]      = 1'b0;
        slot_mode[i]      = MODE_RUNNING;
        total_restarts[i] = '0;
        win_restarts[i]   = '0;
        missed[i]         = '0;
        win_start[i]      = '0;
        dep_mask[i]       = '0;
      end
      expected_reports.delete();
      fails = 0;
    end else begin
      // Register port: track writes, check reads against the tracked value.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_RESTART_WINDOW)
            window_len = pwdata[15:0];
          else
            restart_limit = pwdata[7:0];
        end else begin
          reg_value = (paddr[2] == REG_RESTART_WINDOW) ? {16'd0, window_len}
                                                       : {24'd0, restart_limit};
          if (prdata !== reg_value)
            flag($sformatf("register read at %0d: expected %h, got %h",
                           paddr, reg_value, prdata));
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          flag($sformatf("result transfer with nothing pending: %p", out_item));
        end else begin
          want = expected_reports.pop_front();
          if (out_item.accepted !== want.accepted ||
              out_item.status !== want.status ||
              out_item.unit_mode_out !== want.unit_mode_out ||
              out_item.restart_count_out !== want.restart_count_out ||
              out_item.window_restarts_out !== want.window_restarts_out ||
              out_item.missed_count_out !== want.missed_count_out)
            flag($sformatf("result mismatch: expected %p, got %p", want, out_item));
        end
      end
      if (in_valid && !in_stall)
        expected_reports.insert(expected_reports.size(), health_after(in_item));
    end
    outstanding <= expected_reports.size();
    mismatches  <= fails;
  end

endmodule

### bench/unit_health_supervisor_top_test.sv
// Testbench top for the unit health supervisor: clock, reset, stimulus and verdict.
module unit_health_supervisor_top_test;
  import uhs_pkg::*;

  // Abort once this many cycles pass without any transfer or register access.
  localparam int STALL_LIMIT = 3000;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 100;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [PDATA_W-1:0]  pwdata    = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;

  // Pacing knobs set by the stimulus; the result side reads rx_quiet and hold_request.
  bit tx_quiet     = 1'b0;
  bit rx_quiet     = 1'b0;
  bit hold_request = 1'b0;

  unit_health_supervisor_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  unit_health_supervisor_checker health_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Count cycles with no progress at all; any transfer or bus access resets it.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("[unit_health_supervisor_top] ERROR");
    $finish;
  end

  // Result side: draw a stall length per result, or take the long hold-off
  // once it is requested, then wait with stall low for the next transfer.
  initial begin : result_side
    int n;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = rx_quiet ? 0 : $urandom_range(0, 17);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic in_item_t make_event(logic [OP_W-1:0] op, int unit_no, int other_no,
                                          bit spawn);
    in_item_t ev;
    ev.operation  = op;
    ev.unit       = UNIT_W'(unit_no);
    ev.other_unit = UNIT_W'(other_no);
    ev.spawn_ok   = spawn;
    return ev;
  endfunction

  // Mostly hit a handful of slots so records live long enough to get deep.
  function automatic in_item_t random_event();
    in_item_t ev;
    int       pick;
    ev.unit       = ($urandom_range(0, 3) != 0) ? UNIT_W'($urandom_range(0, 5))
                                                : UNIT_W'($urandom_range(0, 15));
    ev.other_unit = ($urandom_range(0, 3) != 0) ? UNIT_W'($urandom_range(0, 5))
                                                : UNIT_W'($urandom_range(0, 15));
    ev.spawn_ok   = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 12)      ev.operation = OPC_REGISTER;
    else if (pick < 22) ev.operation = OPC_ADD_DEP;
    else if (pick < 34) ev.operation = OPC_HEARTBEAT;
    else if (pick < 50) ev.operation = OPC_MISSED;
    else if (pick < 60) ev.operation = OPC_CRASH;
    else if (pick < 72) ev.operation = OPC_RESTART;
    else if (pick < 76) ev.operation = OPC_STOP;
    else if (pick < 81) ev.operation = OPC_ENFORCE;
    else if (pick < 93) ev.operation = OPC_TICK;
    else if (pick < 97) ev.operation = OPC_QUERY;
    else                ev.operation = OP_W'($urandom_range(int'(OPC_QUERY) + 1,
                                                            (1 << OP_W) - 1));
    return ev;
  endfunction

  // Offer one event and hold it until the transfer. Valid stays high after
  // the transfer; the next call either replaces the payload in the same step
  // or drops valid for its gap, so valid never toggles twice in one step.
  task automatic offer(input in_item_t ev);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every pending result has come back. The
  // pending count is registered, so it lags the last transfer.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One bus access: setup cycle, access cycle, then an idle wait so the
  // next access never raises psel in the step that lowers it.
  task automatic bus_access(input bit wr, input logic idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram both limits with the block idle; junk in the unused upper
  // bits must be dropped. Read both back for the checker.
  task automatic set_limits(input logic [7:0] lim, input logic [15:0] win);
    logic [PDATA_W-1:0] w;
    drain_results();
    w = $urandom();
    w[7:0] = lim;
    bus_access(1'b1, REG_RESTART_LIMIT, w);
    w = $urandom();
    w[15:0] = win;
    bus_access(1'b1, REG_RESTART_WINDOW, w);
    bus_access(1'b0, REG_RESTART_LIMIT, '0);
    bus_access(1'b0, REG_RESTART_WINDOW, '0);
  endtask

  initial begin : stimulus
    int       sent;
    int       u;
    in_item_t ev;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk through the record lifecycle at the reset limits.
    offer(make_event(OPC_QUERY, 3, 0, 1'b1));        // unregistered slot
    offer(make_event(OPC_REGISTER, 0, 0, 1'b0));     // launch failed: no change
    offer(make_event(OPC_REGISTER, 0, 0, 1'b1));
    offer(make_event(OPC_REGISTER, 0, 0, 1'b1));     // slot busy: rejected
    offer(make_event(OPC_REGISTER, 15, 15, 1'b1));
    offer(make_event(OPC_ADD_DEP, 15, 0, 1'b0));     // 15 depends on 0
    offer(make_event(OPC_ADD_DEP, 0, 7, 1'b0));      // provider not registered
    offer(make_event(OPC_ADD_DEP, 15, 15, 1'b0));    // self dependency
    offer(make_event(OPC_MISSED, 0, 0, 1'b0));
    offer(make_event(OPC_MISSED, 0, 0, 1'b0));       // degrade on second miss
    offer(make_event(OPC_HEARTBEAT, 0, 0, 1'b0));    // back to running
    repeat (3) offer(make_event(OPC_MISSED, 0, 0, 1'b0)); // third miss restarts
    offer(make_event(OPC_RESTART, 15, 0, 1'b1));     // not recovering: rejected
    offer(make_event(OPC_RESTART, 0, 0, 1'b1));
    offer(make_event(OPC_CRASH, 15, 0, 1'b0));       // self dependency degrades
    offer(make_event(OPC_CRASH, 0, 0, 1'b0));
    offer(make_event(OPC_RESTART, 0, 0, 1'b0));      // relaunch failed
    offer(make_event(OPC_HEARTBEAT, 0, 0, 1'b1));    // ignored when failed
    offer(make_event(OPC_ENFORCE, 0, 0, 1'b0));      // budget runs on failed too
    offer(make_event(OPC_STOP, 15, 0, 1'b0));
    offer(make_event(OPC_REGISTER, 15, 0, 1'b1));    // reuse failed slot
    offer(make_event(OPC_TICK, 0, 0, 1'b0));
    offer(make_event(OPC_QUERY + 1'b1, 0, 0, 1'b0)); // undefined operations
    offer(make_event({OP_W{1'b1}}, 15, 15, 1'b1));
    offer(make_event(OPC_QUERY, 15, 15, 1'b0));

    // Random phases, each under its own limits. Phase 2 runs with no idling,
    // phase 3 starts with the receiver holding off while the sender streams.
    for (int p = 0; p < 6; p++) begin
      case (p)
        1:       set_limits(8'd0, 16'd0);
        2:       set_limits(8'hFF, 16'hFFFF);
        3:       set_limits(RESTART_LIMIT_RST, RESTART_WINDOW_RST);
        4:       set_limits(8'($urandom_range(1, 4)), 16'($urandom_range(0, 6)));
        5:       set_limits(8'd2, 16'd3);
        default: ;
      endcase
      rx_quiet = (p == 2);
      if (p == 3)
        hold_request = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        tx_quiet = (p == 2) || (p == 3 && sent < 40);
        if ($urandom_range(0, 99) < 15) begin
          // Well-formed lifecycle: register, three misses, relaunch.
          u = $urandom_range(0, 5);
          offer(make_event(OPC_REGISTER, u, 0, 1'b1));
          repeat (3) offer(make_event(OPC_MISSED, u, 0, 1'b0));
          offer(make_event(OPC_RESTART, u, 0, $urandom_range(0, 3) != 0));
          sent += 5;
        end else begin
          offer(random_event());
          sent++;
        end
      end
      // Pause mid-run until all results are back before the next phase.
      drain_results();
    end

    // Saturation: with the widest budget a unit stays recovering forever, so
    // a long run of misses pins the missed and window counts at their ceiling.
    set_limits(8'hFF, 16'hFFFF);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    offer(make_event(OPC_STOP, 9, 0, 1'b0));
    offer(make_event(OPC_REGISTER, 9, 0, 1'b1));
    repeat (260) offer(make_event(OPC_MISSED, 9, 0, 1'b0));
    repeat (4) offer(make_event(OPC_CRASH, 9, 0, 1'b0));
    offer(make_event(OPC_QUERY, 9, 0, 1'b0));
    offer(make_event(OPC_HEARTBEAT, 9, 0, 1'b0));
    offer(make_event(OPC_ENFORCE, 9, 0, 1'b0));

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("[unit_health_supervisor_top] OK");
    else
      $display("[unit_health_supervisor_top] ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/uhs_pkg.sv
sv/uhs_front.sv
sv/uhs_back.sv
sv/unit_health_supervisor_top.sv
sv/uhs_checker.sv
bench/unit_health_supervisor_checker.sv
bench/unit_health_supervisor_top_test.sv
